/* design/shell_command_tokenizer_macros.svh */
// Assertion macros shared by the tokenizer modules.
`ifndef SHELL_COMMAND_TOKENIZER_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SCT_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define SCT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/sct_pkg.sv */
// Shared types, token codes and character constants for the shell tokenizer.
package sct_pkg;

    // token kinds
    localparam logic [3:0] KIND_CHAR   = 4'd0;
    localparam logic [3:0] KIND_WEND   = 4'd1;
    localparam logic [3:0] KIND_PIPE   = 4'd2;
    localparam logic [3:0] KIND_OR     = 4'd3;
    localparam logic [3:0] KIND_BG     = 4'd4;
    localparam logic [3:0] KIND_AND    = 4'd5;
    localparam logic [3:0] KIND_SEMI   = 4'd6;
    localparam logic [3:0] KIND_IN     = 4'd7;
    localparam logic [3:0] KIND_OUT    = 4'd8;
    localparam logic [3:0] KIND_APPEND = 4'd9;
    localparam logic [3:0] KIND_NL     = 4'd10;
    localparam logic [3:0] KIND_END    = 4'd11;

    // characters
    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;

    // event queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] chr;
    } t_tok;

    // one queue entry: the events caused by one input byte (one or two)
    typedef struct packed {
        logic two;
        t_tok t0;
        t_tok t1;
    } t_entry;

    // queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_WORD  = 8'b0000_0010,
        MODE_WESC  = 8'b0000_0100,
        MODE_QUOTE = 8'b0000_1000,
        MODE_QESC  = 8'b0001_0000,
        MODE_PIPE  = 8'b0010_0000,
        MODE_AMP   = 8'b0100_0000,
        MODE_GT    = 8'b1000_0000
    } t_mode;

    function automatic logic f_is_blank(input logic [7:0] b);
        return b inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

    function automatic logic f_ends_word(input logic [7:0] b);
        return f_is_blank(b) || (b inside {CH_NL, CH_PIPE, CH_AMP, CH_SEMI, CH_LT, CH_GT});
    endfunction

    function automatic t_tok f_tok(input logic [3:0] kind, input logic [7:0] chr);
        t_tok t;
        t.kind = kind;
        t.chr  = (kind == KIND_CHAR) ? chr : 8'd0;
        return t;
    endfunction

endpackage

/* design/shell_command_tokenizer.sv */
// Shell command tokenizer: one command-line byte in, shell token events out.
// Each transfer on the input side carries one byte (or an end-of-input mark);
// each transfer on the result side carries one token event: a word character,
// a word end, an operator (|, ||, &, &&, ;, <, >, >>), newline or end. A byte
// causes zero, one or two events; last_of_run marks the last one of a byte.
// Throughput: one byte per clock while the event queue is not full; a byte
// that causes two events is split into two results, so the result side,
// which moves one event per clock while results are taken, sets the
// sustained rate. A four-entry event queue sits between the lexer and the
// output register so either side can stall on its own. Each event is
// written to the queue and then loaded into the output register.
module shell_command_tokenizer
    import sct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_char_value,
    output logic       o_last_of_run
);

    t_qstat qstat;
    t_entry wr_entry, rd_entry;
    logic   q_wr, q_rd;

    // lexer: mode tracking and classification of each byte
    sct_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_qstat        (qstat),
        .o_full         (full),
        .o_q_wr         (q_wr),
        .o_q_entry      (wr_entry)
    );

    // bytes that cause no event never enter the queue
    sct_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_entry (wr_entry),
        .i_rd       (q_rd),
        .o_rd_entry (rd_entry),
        .o_qstat    (qstat)
    );

    // one event per clock into the result register while results are taken
    sct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_entry     (rd_entry),
        .i_qstat       (qstat),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_token_kind  (o_token_kind),
        .o_char_value  (o_char_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* design/sct_front.sv */
// Front end: lexer state and per-byte classification into queue entries.
module sct_front
    import sct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  t_qstat     i_qstat,
    output logic       o_full,
    output logic       o_q_wr,
    output t_entry     o_q_entry
);

`include "shell_command_tokenizer_macros.svh"

    t_mode r_mode, n_mode;
    logic  r_qs, n_qs;

    logic  acc;
    // between-tokens handling of the current byte
    logic  bt_v;
    t_tok  bt_tok;
    t_mode bt_mode;
    logic  bt_qs;
    // first (pre) and second event of this byte
    logic  p_v, s_v, use_bt;
    t_tok  p_tok, s_tok;
    logic [7:0] qc;

    assign o_full = i_qstat.full;
    assign acc    = i_push && !i_qstat.full;

    always_comb begin
        bt_v    = 1'b0;
        bt_tok  = f_tok(KIND_CHAR, i_in_byte);
        bt_mode = MODE_IDLE;
        bt_qs   = r_qs;
        if (!f_is_blank(i_in_byte)) begin
            case (i_in_byte)
                CH_PIPE: bt_mode = MODE_PIPE;
                CH_AMP:  bt_mode = MODE_AMP;
                CH_GT:   bt_mode = MODE_GT;
                CH_SEMI: begin bt_v = 1'b1; bt_tok = f_tok(KIND_SEMI, 8'd0); end
                CH_LT:   begin bt_v = 1'b1; bt_tok = f_tok(KIND_IN, 8'd0); end
                CH_NL:   begin bt_v = 1'b1; bt_tok = f_tok(KIND_NL, 8'd0); end
                CH_DQ:   begin bt_mode = MODE_QUOTE; bt_qs = 1'b0; end
                CH_SQ:   begin bt_mode = MODE_QUOTE; bt_qs = 1'b1; end
                CH_BSL:  bt_mode = MODE_WESC;
                default: begin bt_v = 1'b1; bt_mode = MODE_WORD; end
            endcase
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_qs   = r_qs;
        p_v    = 1'b0;
        p_tok  = f_tok(KIND_CHAR, i_in_byte);
        use_bt = 1'b0;
        qc     = r_qs ? CH_SQ : CH_DQ;
        if (i_end_of_input) begin
            n_mode = MODE_IDLE;
            n_qs   = 1'b0;
            case (r_mode)
                MODE_WORD, MODE_WESC, MODE_QUOTE, MODE_QESC: begin
                    p_v = 1'b1; p_tok = f_tok(KIND_WEND, 8'd0);
                end
                MODE_PIPE: begin p_v = 1'b1; p_tok = f_tok(KIND_PIPE, 8'd0); end
                MODE_AMP:  begin p_v = 1'b1; p_tok = f_tok(KIND_BG, 8'd0); end
                MODE_GT:   begin p_v = 1'b1; p_tok = f_tok(KIND_OUT, 8'd0); end
                default: ;
            endcase
        end else begin
            case (r_mode)
                MODE_IDLE: use_bt = 1'b1;
                MODE_WORD: begin
                    if (f_ends_word(i_in_byte)) begin
                        p_v = 1'b1; p_tok = f_tok(KIND_WEND, 8'd0); use_bt = 1'b1;
                    end else if (i_in_byte == CH_BSL) begin
                        n_mode = MODE_WESC;
                    end else begin
                        p_v = 1'b1;
                    end
                end
                MODE_WESC: begin p_v = 1'b1; n_mode = MODE_WORD; end
                MODE_QUOTE: begin
                    if (i_in_byte == qc) begin
                        p_v = 1'b1; p_tok = f_tok(KIND_WEND, 8'd0); n_mode = MODE_IDLE;
                    end else if (i_in_byte == CH_BSL) begin
                        n_mode = MODE_QESC;
                    end else begin
                        p_v = 1'b1;
                    end
                end
                MODE_QESC: begin p_v = 1'b1; n_mode = MODE_QUOTE; end
                MODE_PIPE: begin
                    p_v = 1'b1; n_mode = MODE_IDLE;
                    if (i_in_byte == CH_PIPE) p_tok = f_tok(KIND_OR, 8'd0);
                    else begin p_tok = f_tok(KIND_PIPE, 8'd0); use_bt = 1'b1; end
                end
                MODE_AMP: begin
                    p_v = 1'b1; n_mode = MODE_IDLE;
                    if (i_in_byte == CH_AMP) p_tok = f_tok(KIND_AND, 8'd0);
                    else begin p_tok = f_tok(KIND_BG, 8'd0); use_bt = 1'b1; end
                end
                default: begin
                    p_v = 1'b1; n_mode = MODE_IDLE;
                    if (i_in_byte == CH_GT) p_tok = f_tok(KIND_APPEND, 8'd0);
                    else begin p_tok = f_tok(KIND_OUT, 8'd0); use_bt = 1'b1; end
                end
            endcase
            if (use_bt) begin
                n_mode = bt_mode;
                n_qs   = bt_qs;
            end
        end
    end

    // second event: between-tokens output, or the end mark
    assign s_v   = i_end_of_input ? 1'b1 : (use_bt && bt_v);
    assign s_tok = i_end_of_input ? f_tok(KIND_END, 8'd0) : bt_tok;

    assign o_q_wr          = acc && (p_v || s_v);
    assign o_q_entry.two   = p_v && s_v;
    assign o_q_entry.t0    = p_v ? p_tok : s_tok;
    assign o_q_entry.t1    = s_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_qs   <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_qs   <= n_qs;
        end
    end

    `SCT_ASSERT_NEXT(a_eoi_idle, acc && i_end_of_input, r_mode == MODE_IDLE && !r_qs, "end of input must leave the lexer idle")
    `SCT_ASSERT_IMPL(a_eoi_writes, acc && i_end_of_input, o_q_wr, "end of input must queue an end event")

endmodule

/* design/sct_queue.sv */
// Short event queue decoupling the lexer front end from the output back end.
module sct_queue
    import sct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_entry,
    input  logic   i_rd,
    output t_entry o_rd_entry,
    output t_qstat o_qstat
);

`include "shell_command_tokenizer_macros.svh"

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_rd_entry    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wr_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + QAW'(1);
            if (i_rd) r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(i_rd);
        end
    end

    `SCT_ASSERT_ALWAYS(a_cnt_range, r_cnt <= (QAW+1)'(QDEPTH), "queue count beyond depth")
    `SCT_ASSERT_IMPL(a_no_underflow, i_rd, !o_qstat.empty, "read from empty queue")

endmodule

/* design/sct_back.sv */
// Back end: splits queue entries into single events and holds the result register.
module sct_back
    import sct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_q_entry,
    input  t_qstat     i_qstat,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_char_value,
    output logic       o_last_of_run
);

`include "shell_command_tokenizer_macros.svh"

    logic r_valid, r_last, r_sub;
    t_tok r_tok;
    logic load, last;
    t_tok cur;

    assign load   = !i_qstat.empty && (!r_valid || i_pop);
    assign cur    = r_sub ? i_q_entry.t1 : i_q_entry.t0;
    assign last   = !i_q_entry.two || r_sub;
    assign o_q_rd = load && last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= cur;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && !i_pop);
            if (load) r_sub <= !last;
        end
    end

    assign o_empty       = !r_valid;
    assign o_token_kind  = r_tok.kind;
    assign o_char_value  = r_tok.chr;
    assign o_last_of_run = r_last;

    `SCT_ASSERT_IMPL(a_sub_has_entry, r_sub, !i_qstat.empty && i_q_entry.two, "second event lost")

endmodule
